// File: src/tcfo_pkg.sv
// Package for the two-class FIFO with oldest-first service.
// Holds sizes, command and status codes, and the struct types shared by every module except tcfo_ram.
// No dependencies.
`default_nettype none

package tcfo_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int STAMP_BITS  = 16;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = STAMP_BITS + TAG_BITS;

    localparam int IN_TAG_W  = 16;
    localparam int OUT_TAG_W = 16;

    typedef enum logic [1:0] {
        CMD_ENQ      = 2'd0,
        CMD_DEQ_ANY  = 2'd1,
        CMD_DEQ_ZERO = 2'd2,
        CMD_DEQ_ONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]          command;
        logic                item_class;
        logic [IN_TAG_W-1:0] item_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_TAG_W-1:0] out_tag;
        logic                 out_class;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    strobe;
        logic    push;
        logic    pop;
        logic    pop_class;
        t_status status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic cls;
        logic empty0;
        logic empty1;
        logic full0;
        logic full1;
        logic zero_newer;
    } t_dp_status;

endpackage

`default_nettype wire

// File: src/two_class_fifo_oldest_first_top.sv
// Top level of the two-class FIFO with oldest-first service.
// Depends on tcfo_pkg, tcfo_ctrl and tcfo_dp.
//
// A command is taken when start is high and busy is low. Each command has the accept
// cycle, in which both head entries are read from the registered-read entry RAMs, and
// the following cycle, in which busy is high and the single result is shown on o_out
// with o_done high for that one cycle; state is updated at its end. The receiver
// cannot stall: o_out is valid only while o_done is high. Errors (dequeue from an empty
// queue, enqueue into a full one) report a status code, a zero tag and class, and leave
// all state untouched.
`default_nettype none

module two_class_fifo_oldest_first_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tcfo_pkg::t_in  i_in,
    output logic                o_done,
    output tcfo_pkg::t_out      o_out
);
    import tcfo_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    tcfo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_st    (dp_st),
        .o_cmd   (dp_cmd)
    );

    tcfo_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_st    (dp_st),
        .o_out   (o_out)
    );

    assign o_done = dp_cmd.strobe;

endmodule

`default_nettype wire

// File: src/tcfo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/tcfo_ctrl.sv
// Controller: accepts a command, then decides push, pop or error from datapath status.
// Depends on tcfo_pkg.
`default_nettype none

module tcfo_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tcfo_pkg::t_dp_status i_st,
    output tcfo_pkg::t_dp_cmd        o_cmd
);
    import tcfo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.status    = ST_OK;
        busy            = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                busy         = 1'b1;
                o_cmd.strobe = 1'b1;
                n_state      = S_IDLE;
                unique case (i_st.cmd)
                    CMD_ENQ: begin
                        if (i_st.cls ? i_st.full1 : i_st.full0) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    CMD_DEQ_ZERO: begin
                        if (i_st.empty0) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.pop       = 1'b1;
                            o_cmd.pop_class = 1'b0;
                        end
                    end
                    CMD_DEQ_ONE: begin
                        if (i_st.empty1) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.pop       = 1'b1;
                            o_cmd.pop_class = 1'b1;
                        end
                    end
                    CMD_DEQ_ANY: begin
                        priority if (i_st.empty0 && i_st.empty1) begin
                            o_cmd.status = ST_EMPTY;
                        end else if (i_st.empty0) begin
                            o_cmd.pop       = 1'b1;
                            o_cmd.pop_class = 1'b1;
                        end else if (i_st.empty1) begin
                            o_cmd.pop       = 1'b1;
                            o_cmd.pop_class = 1'b0;
                        end else begin
                            // equal stamps go to class one
                            o_cmd.pop       = 1'b1;
                            o_cmd.pop_class = i_st.zero_newer;
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/tcfo_dp.sv
// Datapath: command latch, per-class head/count, arrival counter, two entry RAMs.
// Depends on tcfo_pkg and tcfo_ram.
`default_nettype none

module tcfo_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tcfo_pkg::t_in        i_in,
    input  wire tcfo_pkg::t_dp_cmd    i_cmd,
    output tcfo_pkg::t_dp_status      o_st,
    output tcfo_pkg::t_out            o_out
);
    import tcfo_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    logic [1:0]            r_cmd;
    logic                  r_cls;
    logic [TAG_BITS-1:0]   r_tag;
    logic [IDX_W-1:0]      r_head [2];
    logic [CNT_W-1:0]      r_cnt  [2];
    logic [STAMP_BITS-1:0] r_arrival;

    logic [IDX_W-1:0]      n_head [2];
    logic [CNT_W-1:0]      n_cnt  [2];
    logic [STAMP_BITS-1:0] n_arrival;

    logic [ENTRY_W-1:0]    rdata [2];
    logic [SUM_W-1:0]      tail_sum;
    logic [IDX_W-1:0]      tail;
    logic [STAMP_BITS-1:0] diff;
    logic [TAG_BITS-1:0]   pop_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in.command;
            r_cls <= i_in.item_class;
            r_tag <= TAG_BITS'(i_in.item_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_arrival <= '0;
        end else begin
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_arrival <= n_arrival;
        end
    end

    always_comb begin
        tail_sum = SUM_W'(r_head[r_cls]) + SUM_W'(r_cnt[r_cls]);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail = IDX_W'(tail_sum);
    end

    always_comb begin
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_arrival = r_arrival;
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.push && (r_cls == 1'(k))) begin
                n_cnt[k] = r_cnt[k] + 1'b1;
            end
            if (i_cmd.pop && (i_cmd.pop_class == 1'(k))) begin
                n_cnt[k] = r_cnt[k] - 1'b1;
                if (r_head[k] == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_head[k] = '0;
                end else begin
                    n_head[k] = r_head[k] + 1'b1;
                end
            end
        end
        if (i_cmd.push) begin
            n_arrival = r_arrival + 1'b1;
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_store
        tcfo_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.push && (r_cls == 1'(k))),
            .i_waddr (tail),
            .i_wdata ({r_arrival, r_tag}),
            .i_raddr (r_head[k]),
            .o_rdata (rdata[k])
        );
    end

    // head stamps: class zero newer or equal when the wrapped difference is non-negative
    assign diff = rdata[0][ENTRY_W-1:TAG_BITS] - rdata[1][ENTRY_W-1:TAG_BITS];

    always_comb begin
        o_st.cmd        = t_cmd'(r_cmd);
        o_st.cls        = r_cls;
        o_st.empty0     = (r_cnt[0] == '0);
        o_st.empty1     = (r_cnt[1] == '0);
        o_st.full0      = (r_cnt[0] == CNT_W'(QUEUE_DEPTH));
        o_st.full1      = (r_cnt[1] == CNT_W'(QUEUE_DEPTH));
        o_st.zero_newer = !diff[STAMP_BITS-1];
    end

    assign pop_tag = i_cmd.pop_class ? rdata[1][TAG_BITS-1:0] : rdata[0][TAG_BITS-1:0];

    always_comb begin
        o_out.status    = i_cmd.status;
        o_out.out_tag   = i_cmd.pop ? OUT_TAG_W'(pop_tag) : '0;
        o_out.out_class = i_cmd.pop ? i_cmd.pop_class : 1'b0;
    end

endmodule

`default_nettype wire

// File: src/tcfo_checker.sv
// Port-level checker for the two-class FIFO top level, bound to it below.
// Depends on tcfo_pkg.
`default_nettype none

module tcfo_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_done,
    input wire tcfo_pkg::t_out o_out
);
    import tcfo_pkg::*;

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted transaction gave no result in the next cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while not busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_out.status != ST_OK)) |-> (o_out.out_tag == '0 && !o_out.out_class))
        else $error("error result carries tag or class");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.status == ST_OK || o_out.status == ST_EMPTY ||
                    o_out.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind two_class_fifo_oldest_first_top tcfo_checker u_tcfo_checker (.*);

`default_nettype wire
